@@ rtl/iecalc_pkg.sv @@
// Shared types and constants for the infix expression stream calculator.
// Used by iecalc_ctrl, iecalc_dp and infix_expression_stream_calc_core.
// Depends on nothing else.
package iecalc_pkg;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  localparam int VALUE_W = 32;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_OTHER = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    PH_LEFT  = 2'd0,
    PH_OPER  = 2'd1,
    PH_GAP   = 2'd2,
    PH_RIGHT = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DIV0  = 2'd1,
    STAT_BADOP = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PREP = 2'd1,
    S_ITER = 2'd2,
    S_FIX  = 2'd3
  } fsm_t;

  typedef struct packed {
    logic take_byte;
    logic start;
    logic prep;
    logic iter;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic finish_byte;
    logic iterate;
    logic cnt_last;
  } stat_t;

endpackage

@@ rtl/iecalc_ctrl.sv @@
// Controller state machine of the expression calculator.
// Sequences parsing, operand setup, the shared multiply/divide unit and the
// output register. Depends on iecalc_pkg.
module iecalc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  iecalc_pkg::stat_t  stat,
  output iecalc_pkg::cmd_t   cmd
);
  import iecalc_pkg::*;

  fsm_t state, state_next;
  logic accept;
  logic slot_free;

  assign accept    = in_valid && (state == S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && stat.finish_byte) state_next = S_PREP;
      S_PREP: state_next = stat.iterate ? S_ITER : S_FIX;
      S_ITER: if (stat.cnt_last) state_next = S_FIX;
      S_FIX:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_byte = accept && !stat.finish_byte;
        cmd.start     = accept && stat.finish_byte;
      end
      S_PREP: cmd.prep = 1'b1;
      S_ITER: cmd.iter = 1'b1;
      S_FIX:  cmd.load_out = slot_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_finish_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_PREP)
    else $error("line end did not start a computation");

  a_iter_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER) && stat.cnt_last |=> state == S_FIX)
    else $error("iteration overran its count");

endmodule

@@ rtl/iecalc_dp.sv @@
// Datapath of the expression calculator: parser registers, operand latch,
// shift-add multiplier / restoring divider and result register.
// Depends on iecalc_pkg.
module iecalc_dp #(
  parameter int WORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  iecalc_pkg::cmd_t   cmd,
  input  logic [7:0]         ch,
  input  logic               end_of_text,
  output iecalc_pkg::stat_t  stat,
  output logic [31:0]        value,
  output logic [1:0]         status,
  output logic               last_result
);
  import iecalc_pkg::*;

  localparam int CW = $clog2(WORD_WIDTH);

  function automatic logic [WORD_WIDTH-1:0] digit(input logic [WORD_WIDTH-1:0] a,
                                                  input logic [7:0] b);
    return (a << 3) + (a << 1) + WORD_WIDTH'(b) - WORD_WIDTH'(CH_ZERO);
  endfunction

  phase_t                phase;
  op_t                   op_code;
  op_t                   op_r;
  logic [WORD_WIDTH-1:0] left_accum, right_accum;
  logic                  left_negative, right_negative;
  logic [WORD_WIDTH-1:0] opa, opb;
  logic [WORD_WIDTH-1:0] wacc, wx, wy;
  logic [CW-1:0]         cnt;
  logic                  qneg;
  logic                  last_r;

  logic [WORD_WIDTH:0]   trial, diff;
  logic                  ge;
  logic [WORD_WIDTH-1:0] fix_value;
  logic [1:0]            fix_status;
  logic [WORD_WIDTH+VALUE_W-1:0] value_ext;

  assign stat.finish_byte = end_of_text || (ch == CH_LF);
  assign stat.iterate     = (op_r == OP_MUL) || ((op_r == OP_DIV) && (opb != '0));
  assign stat.cnt_last    = (cnt == CW'(WORD_WIDTH - 1));

  assign trial = {wacc, wx[WORD_WIDTH-1]};
  assign diff  = trial - {1'b0, wy};
  assign ge    = trial >= {1'b0, wy};

  always_comb begin
    fix_value  = '0;
    fix_status = STAT_OK;
    case (op_r)
      OP_ADD: fix_value = opa + opb;
      OP_SUB: fix_value = opa - opb;
      OP_MUL: fix_value = wacc;
      OP_DIV: begin
        if (opb == '0) begin
          fix_status = STAT_DIV0;
        end else begin
          fix_value = qneg ? -wx : wx;
        end
      end
      default: fix_status = STAT_BADOP;
    endcase
  end

  assign value_ext = {{VALUE_W{1'b0}}, fix_value};

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      phase          <= PH_LEFT;
      op_code        <= OP_NONE;
      left_accum     <= '0;
      right_accum    <= '0;
      left_negative  <= 1'b0;
      right_negative <= 1'b0;
    end else if (cmd.take_byte) begin
      case (phase)
        PH_LEFT: begin
          if (ch == CH_SP) begin
            phase <= PH_OPER;
          end else if (ch == CH_MINUS) begin
            left_negative <= 1'b1;
          end else begin
            left_accum <= digit(left_accum, ch);
          end
        end
        PH_OPER: begin
          case (ch)
            CH_PLUS:  op_code <= OP_ADD;
            CH_MINUS: op_code <= OP_SUB;
            CH_STAR:  op_code <= OP_MUL;
            CH_SLASH: op_code <= OP_DIV;
            default:  op_code <= OP_OTHER;
          endcase
          phase <= PH_GAP;
        end
        PH_GAP: begin
          if (ch == CH_SP) begin
            phase <= PH_RIGHT;
          end
        end
        default: begin
          if (ch == CH_MINUS) begin
            right_negative <= 1'b1;
          end else begin
            right_accum <= digit(right_accum, ch);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      opa    <= left_negative ? -left_accum : left_accum;
      opb    <= right_negative ? -right_accum : right_accum;
      op_r   <= op_code;
      last_r <= end_of_text;
    end
    if (cmd.prep) begin
      wacc <= '0;
      cnt  <= '0;
      qneg <= opa[WORD_WIDTH-1] ^ opb[WORD_WIDTH-1];
      if (op_r == OP_DIV) begin
        wx <= opa[WORD_WIDTH-1] ? -opa : opa;
        wy <= opb[WORD_WIDTH-1] ? -opb : opb;
      end else begin
        wx <= opa;
        wy <= opb;
      end
    end else if (cmd.iter) begin
      cnt <= cnt + 1'b1;
      if (op_r == OP_DIV) begin
        wacc <= ge ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
        wx   <= {wx[WORD_WIDTH-2:0], ge};
      end else begin
        if (wy[0]) begin
          wacc <= wacc + wx;
        end
        wx <= wx << 1;
        wy <= wy >> 1;
      end
    end
    if (cmd.load_out) begin
      value       <= value_ext[VALUE_W-1:0];
      status      <= fix_status;
      last_result <= last_r;
    end
  end

endmodule

@@ rtl/infix_expression_stream_calc_core.sv @@
// Infix expression stream calculator, top level.
// Parses lines of the form "operand op operand" one byte per transaction and
// returns one result per line end or end-of-text transaction.
// Input channel: in_valid/in_stall with ch and end_of_text. A transaction with
// end_of_text high, or with ch equal to newline, closes the expression.
// Output channel: out_valid/out_stall with value, status and last_result.
// Ordinary bytes are taken one per cycle while the block is idle; in_stall is
// low whenever the block is idle. A closing transaction occupies the block:
// for +, -, unknown operators and division by zero the controller goes from
// operand setup (S_PREP) straight to S_FIX; for * and / it first runs S_ITER,
// one bit per cycle through a shared shift-add / restoring divide unit.
// S_FIX registers the result once the output slot is free, and the block then
// returns to idle, so the next byte is accepted after the result is registered.
// The result sits in an output register, so bytes keep flowing while it
// waits; a stalled receiver holds the result and blocks the next closing
// transaction from completing, which then holds in_stall high.
// Synchronous reset clears the parser to the first operand and drops
// out_valid; no result is pending after reset.
// Depends on iecalc_pkg, iecalc_ctrl and iecalc_dp.
module infix_expression_stream_calc_core #(
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic [1:0]  status,
  output logic        last_result
);
  import iecalc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  iecalc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  iecalc_dp #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .ch          (ch),
    .end_of_text (end_of_text),
    .stat        (stat),
    .value       (value),
    .status      (status),
    .last_result (last_result)
  );

endmodule
